// ===== rtl/core/xref_stream_entry_decoder_macros.svh =====
// Assertion macros for the cross-reference stream entry decoder.
`ifndef XREF_STREAM_ENTRY_DECODER_MACROS_SVH
`define XREF_STREAM_ENTRY_DECODER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define XSED_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("xsed assertion failed");

// Next-cycle implication, checked out of reset.
`define XSED_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("xsed assertion failed");

`else

`define XSED_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define XSED_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== rtl/core/xsed_pkg.sv =====
// Shared types, codes and constants of the cross-reference stream entry decoder.
package xsed_pkg;

    localparam int MAX_FIELD_BYTES_DEF = 8;
    localparam int REG_W               = 4;
    localparam int CFG_INDEX_W         = 2;
    localparam int Q_DEPTH             = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_WIDTH  = 2'd2;

    localparam logic [REG_W-1:0] TYPE_WIDTH_RST   = 4'd1;
    localparam logic [REG_W-1:0] SECOND_WIDTH_RST = 4'd4;
    localparam logic [REG_W-1:0] THIRD_WIDTH_RST  = 4'd2;

    // Input operations
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_BYTE   = 1'b1;

    // Entry kinds
    localparam logic [1:0] KIND_FREE       = 2'd0;
    localparam logic [1:0] KIND_IN_USE     = 2'd1;
    localparam logic [1:0] KIND_COMPRESSED = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_BAD_TYPE   = 2'd1;
    localparam logic [1:0] ERR_NO_SECTION = 2'd2;
    localparam logic [1:0] ERR_ZERO_WIDTH = 2'd3;

    typedef struct packed {
        logic [31:0] object_number;
        logic [1:0]  entry_kind;
        logic [63:0] second_value;
        logic [31:0] third_value;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result result;
    } t_front_out;

    function automatic logic [REG_W-1:0] f_clamp_width(input logic [REG_W-1:0] w,
                                                       input logic [REG_W-1:0] max_w);
        f_clamp_width = (w > max_w) ? max_w : w;
    endfunction

endpackage

// ===== rtl/core/xsed_queue.sv =====
// Short result queue between the entry decoder front and the output stream.
module xsed_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xsed_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output xsed_pkg::t_result o_result
);
    import xsed_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

    t_result          r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign o_full   = (r_count == FULL_CNT);
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign w_pop    = o_valid & i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

endmodule

// ===== rtl/core/xsed_front.sv =====
// Front of the entry decoder: width registers, subsection state and field assembly.
module xsed_front #(
    parameter int MAX_FIELD_BYTES = xsed_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [xsed_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [xsed_pkg::REG_W-1:0]       i_cfg_wdata,
    input  logic                             i_accept,
    input  logic                             i_operation,
    input  logic [7:0]                       i_byte_value,
    input  logic [31:0]                      i_first_object,
    input  logic [31:0]                      i_entry_count,
    output xsed_pkg::t_front_out             o_front
);
    import xsed_pkg::*;

    localparam int POS_W = $clog2(3 * MAX_FIELD_BYTES + 1);
    localparam logic [REG_W-1:0] MAX_W = REG_W'(MAX_FIELD_BYTES);

    logic [REG_W-1:0] r_type_width, r_second_width, r_third_width;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_type_hi, n_type_hi;
    logic [7:0]       r_type_lo, n_type_lo;
    logic [63:0]      r_second_acc, n_second_acc;
    logic [31:0]      r_third_acc, n_third_acc;
    logic [31:0]      r_cur_obj, n_cur_obj;
    logic [31:0]      r_remaining, n_remaining;

    logic [POS_W-1:0] w_tw, w_sw, w_hw, w_ts, w_total;
    logic [POS_W:0]   w_pos_inc;
    logic             w_bad_type;
    t_front_out       w_out;

    always_comb begin
        w_tw    = POS_W'(f_clamp_width(r_type_width, MAX_W));
        w_sw    = POS_W'(f_clamp_width(r_second_width, MAX_W));
        w_hw    = POS_W'(f_clamp_width(r_third_width, MAX_W));
        w_ts    = w_tw + w_sw;
        w_total = w_ts + w_hw;
    end

    always_comb begin
        n_pos        = r_pos;
        n_type_hi    = r_type_hi;
        n_type_lo    = r_type_lo;
        n_second_acc = r_second_acc;
        n_third_acc  = r_third_acc;
        n_cur_obj    = r_cur_obj;
        n_remaining  = r_remaining;
        w_pos_inc    = {1'b0, r_pos} + (POS_W+1)'(1);
        w_bad_type   = 1'b0;
        w_out        = '0;

        if (i_accept) begin
            if (i_operation == OP_HEADER) begin
                n_pos        = '0;
                n_type_hi    = 1'b0;
                n_type_lo    = '0;
                n_second_acc = '0;
                n_third_acc  = '0;
                if (w_total == '0) begin
                    n_remaining                 = '0;
                    w_out.push                  = 1'b1;
                    w_out.result.error_code     = ERR_ZERO_WIDTH;
                end else begin
                    n_cur_obj   = i_first_object;
                    n_remaining = i_entry_count;
                end
            end else if (r_remaining == '0) begin
                w_out.push              = 1'b1;
                w_out.result.error_code = ERR_NO_SECTION;
            end else if (w_total == '0) begin
                w_out.push              = 1'b1;
                w_out.result.error_code = ERR_ZERO_WIDTH;
            end else begin
                // Fold the byte into the field that owns this position
                if (r_pos < w_tw) begin
                    n_type_hi = r_type_hi | (r_type_lo != '0);
                    n_type_lo = i_byte_value;
                end else if (r_pos < w_ts) begin
                    n_second_acc = {r_second_acc[55:0], i_byte_value};
                end else begin
                    n_third_acc = {r_third_acc[23:0], i_byte_value};
                end
                n_pos = w_pos_inc[POS_W-1:0];

                if (w_pos_inc >= {1'b0, w_total}) begin
                    w_out.push                 = 1'b1;
                    w_out.result.object_number = r_cur_obj;
                    if (w_tw != '0) begin
                        w_bad_type = n_type_hi | (n_type_lo > 8'(KIND_COMPRESSED));
                    end
                    if (w_bad_type) begin
                        w_out.result.error_code = ERR_BAD_TYPE;
                    end else begin
                        w_out.result.entry_kind   = (w_tw == '0) ? KIND_IN_USE
                                                                  : n_type_lo[1:0];
                        w_out.result.second_value = n_second_acc;
                        w_out.result.third_value  = n_third_acc;
                        w_out.result.error_code   = ERR_OK;
                    end
                    // Advance to the next entry and drop the accumulated fields
                    n_cur_obj    = r_cur_obj + 32'd1;
                    n_remaining  = r_remaining - 32'd1;
                    n_pos        = '0;
                    n_type_hi    = 1'b0;
                    n_type_lo    = '0;
                    n_second_acc = '0;
                    n_third_acc  = '0;
                end
            end
        end
    end

    assign o_front = w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_width   <= TYPE_WIDTH_RST;
            r_second_width <= SECOND_WIDTH_RST;
            r_third_width  <= THIRD_WIDTH_RST;
            r_pos          <= '0;
            r_type_hi      <= 1'b0;
            r_type_lo      <= '0;
            r_second_acc   <= '0;
            r_third_acc    <= '0;
            r_cur_obj      <= '0;
            r_remaining    <= '0;
        end else begin
            r_pos        <= n_pos;
            r_type_hi    <= n_type_hi;
            r_type_lo    <= n_type_lo;
            r_second_acc <= n_second_acc;
            r_third_acc  <= n_third_acc;
            r_cur_obj    <= n_cur_obj;
            r_remaining  <= n_remaining;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TYPE_WIDTH:   r_type_width   <= i_cfg_wdata;
                    REG_SECOND_WIDTH: r_second_width <= i_cfg_wdata;
                    REG_THIRD_WIDTH:  r_third_width  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/xref_stream_entry_decoder.sv =====
// Top level of the cross-reference stream entry decoder.
//
//  channel    dir  handshake                       payload
//  s_axis     in   i_s_axis_tvalid/o_s_axis_tready tdata 72 b, tuser 1 b
//  m_axis     out  o_m_axis_tvalid/i_m_axis_tready tdata 128 b, tuser 4 b
//  cfg        in   i_cfg_we (no wait)              index 2 b, data 4 b
//
// One transaction per cycle on s_axis while the result queue has room; the front
// folds each byte in the cycle it is accepted, and pushes an entry's result into
// the queue in the cycle its last byte is accepted. A two-entry result queue parts
// the two sides: s_axis stalls only when it is full. Reset is synchronous and
// active low; widths return to 1/4/2 and no subsection is open.
`include "xref_stream_entry_decoder_macros.svh"

module xref_stream_entry_decoder #(
    parameter int MAX_FIELD_BYTES = xsed_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [7:0] byte_value, [39:8] first_object, [71:40] entry_count
    input  logic [71:0]                      i_s_axis_tdata,
    // [0] operation
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] object_number, [95:32] second_value, [127:96] third_value
    output logic [127:0]                     o_m_axis_tdata,
    // [1:0] entry_kind, [3:2] error_code
    output logic [3:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [xsed_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [xsed_pkg::REG_W-1:0]       i_cfg_wdata
);
    import xsed_pkg::*;

    logic       w_accept;
    logic       w_full;
    t_front_out w_front;
    t_result    w_q_result;

    assign o_s_axis_tready = ~w_full;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    xsed_front #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (w_accept),
        .i_operation    (i_s_axis_tuser),
        .i_byte_value   (i_s_axis_tdata[7:0]),
        .i_first_object (i_s_axis_tdata[39:8]),
        .i_entry_count  (i_s_axis_tdata[71:40]),
        .o_front        (w_front)
    );

    xsed_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_front.push),
        .i_result (w_front.result),
        .o_full   (w_full),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_q_result)
    );

    assign o_m_axis_tdata = {w_q_result.third_value, w_q_result.second_value,
                             w_q_result.object_number};
    assign o_m_axis_tuser = {w_q_result.error_code, w_q_result.entry_kind};

    `XSED_ASSERT_IMPLIES(a_push_needs_accept, i_clk, i_rst_n, w_front.push, w_accept)
    `XSED_ASSERT_IMPLIES(a_no_kind_three, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser[1:0] != 2'd3)
    `XSED_ASSERT_IMPLIES(a_error_clears_fields, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser[3:2] != ERR_OK), (o_m_axis_tuser[1:0] == KIND_FREE) && (o_m_axis_tdata[127:32] == '0))
    `XSED_ASSERT_NEXT(a_push_shows_result, i_clk, i_rst_n, w_front.push, o_m_axis_tvalid)

endmodule
